/* rtl/mtne_pkg.sv */
// ----------------------------------------------------------------------------
// mtne_pkg
// Shared types, widths and id constants of the MIDI track note extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtne_pkg;

  // delta time width, 8 to 32
  localparam int DeltaBits = 28;
  localparam int SkipBits  = 28;
  localparam int RestBits  = 28;
  localparam int ChunkBits = 32;
  localparam int OpenBits  = 16;

  // result queue
  localparam int QDepth   = 4;
  localparam int QPtrBits = $clog2(QDepth);
  localparam int QCntBits = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    KIND_REST       = 3'd0,
    KIND_NEW_CHORD  = 3'd1,
    KIND_JOIN_CHORD = 3'd2,
    KIND_BAD_HEADER = 3'd3,
    KIND_BAD_CHUNK  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] note_number;
    logic       last;
  } note_t;

  // up to two results produced by one file byte
  typedef struct packed {
    logic [1:0] count;
    note_t      item0;
    note_t      item1;
  } push_t;

  localparam logic [3:0] NibMeta    = 4'd15;
  localparam logic [3:0] NibNoteOn  = 4'd9;
  localparam logic [3:0] NibNoteOff = 4'd8;
  localparam logic [3:0] NibProgram = 4'd12;
  localparam logic [3:0] NibPressure = 4'd13;
  localparam logic [3:0] NibPolyAt  = 4'd10;

  localparam logic [3:0] HdrLastIdx = 4'd13;
  localparam logic [3:0] IdLastIdx  = 4'd3;

  // "MThd"
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h4D;
      2'd1:    r = 8'h54;
      2'd2:    r = 8'h68;
      default: r = 8'h64;
    endcase
    return r;
  endfunction

  // "MTrk"
  function automatic logic [7:0] trk_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h4D;
      2'd1:    r = 8'h54;
      2'd2:    r = 8'h72;
      default: r = 8'h6B;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/mtne_byte_if.sv */
// ----------------------------------------------------------------------------
// mtne_byte_if
// Request channel carrying one byte of the MIDI file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mtne_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;

  modport source (output valid, output file_byte, input ready);
  modport sink   (input valid, input file_byte, output ready);
endinterface

`default_nettype wire

/* rtl/mtne_note_if.sv */
// ----------------------------------------------------------------------------
// mtne_note_if
// Request channel carrying one note, rest or error result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mtne_note_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] note_number;
  logic       last;

  modport source (output valid, output kind, output note_number, output last,
                  input ready);
  modport sink   (input valid, input kind, input note_number, input last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/mtne_parser.sv */
// ----------------------------------------------------------------------------
// mtne_parser
// Input byte register and combinational file parser with a registered
// result output, producing up to two results per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtne_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  mtne_byte_if.sink                         byte_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [mtne_pkg::RestBits-1:0] cfg_wdata_i,
  input  wire logic                         room_i,
  output mtne_pkg::push_t                   push_o
);

  typedef enum logic [3:0] {
    PH_HDR, PH_ID, PH_LEN, PH_DELTA, PH_STATUS, PH_MTYPE, PH_VLEN, PH_SKIP, PH_DATA
  } phase_e;

  typedef enum logic [1:0] {
    COL_IDLE   = 2'd0,
    COL_ACTIVE = 2'd1,
    COL_DONE   = 2'd2
  } collect_e;

  logic                            byte_vq;
  logic [7:0]                      byte_q;
  logic                            advance;

  logic [mtne_pkg::RestBits-1:0]   min_rest_q;

  phase_e                          phase_q, phase_d;
  logic [3:0]                      idx_q, idx_d;
  logic [mtne_pkg::ChunkBits-1:0]  chunk_q, chunk_d;
  logic [mtne_pkg::DeltaBits-1:0]  delta_q, delta_d;
  logic [mtne_pkg::SkipBits-1:0]   skip_q, skip_d;
  logic [3:0]                      nib_q, nib_d;
  logic [7:0]                      first_q, first_d;
  logic [mtne_pkg::OpenBits-1:0]   open_q, open_d;
  logic                            prev_q, prev_d;
  collect_e                        collect_q, collect_d;
  logic                            halted_q, halted_d;
  mtne_pkg::push_t                 push_d;

  // event completion
  logic [7:0]                      ev_first;
  logic                            ev_rest;
  logic                            ev_join;
  collect_e                        ev_collect;
  logic [mtne_pkg::OpenBits-1:0]   ev_open;
  logic                            ev_prev;
  mtne_pkg::push_t                 ev_push;

  assign advance      = byte_vq && room_i;
  assign byte_i.ready = !byte_vq || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vq <= 1'b0;
    end else if (byte_i.ready) begin
      byte_vq <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      byte_q <= byte_i.file_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rest_q <= '0;
    end else if (cfg_we_i) begin
      min_rest_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    ev_first   = (idx_q == 4'd0) ? byte_q : first_q;
    ev_collect = collect_q;
    ev_open    = open_q;
    ev_prev    = prev_q;
    ev_push    = '0;
    ev_rest    = (open_q == '0) && (32'(delta_q) > 32'(min_rest_q));
    ev_join    = prev_q && (delta_q == '0);
    if (nib_q == mtne_pkg::NibNoteOn) begin
      if (collect_q == COL_IDLE) begin
        ev_collect = COL_ACTIVE;
      end
      if (collect_q != COL_DONE) begin
        ev_push.item1.kind        = ev_join ? mtne_pkg::KIND_JOIN_CHORD
                                            : mtne_pkg::KIND_NEW_CHORD;
        ev_push.item1.note_number = ev_first;
        ev_push.item1.last        = 1'b1;
        if (ev_rest) begin
          ev_push.count             = 2'd2;
          ev_push.item0.kind        = mtne_pkg::KIND_REST;
          ev_push.item0.note_number = 8'd0;
          ev_push.item0.last        = 1'b0;
        end else begin
          ev_push.count = 2'd1;
          ev_push.item0 = ev_push.item1;
        end
        ev_open = open_q + 1'b1;
        ev_prev = 1'b1;
      end
    end else if (nib_q == mtne_pkg::NibNoteOff) begin
      ev_open = open_q - 1'b1;
      if (delta_q != '0) begin
        ev_prev = 1'b0;
      end
    end else if (delta_q != '0 && nib_q != mtne_pkg::NibPolyAt) begin
      ev_prev = 1'b0;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    chunk_d   = chunk_q;
    delta_d   = delta_q;
    skip_d    = skip_q;
    nib_d     = nib_q;
    first_d   = first_q;
    open_d    = open_q;
    prev_d    = prev_q;
    collect_d = collect_q;
    halted_d  = halted_q;
    push_d    = '0;
    if (advance && !halted_q) begin
      case (phase_q)
        PH_HDR: begin
          if (idx_q < 4'd4 && byte_q != mtne_pkg::hdr_byte(idx_q[1:0])) begin
            push_d.count      = 2'd1;
            push_d.item0.kind = mtne_pkg::KIND_BAD_HEADER;
            push_d.item0.last = 1'b1;
            halted_d          = 1'b1;
          end else if (idx_q >= mtne_pkg::HdrLastIdx) begin
            phase_d = PH_ID;
            idx_d   = 4'd0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PH_ID: begin
          if (byte_q != mtne_pkg::trk_byte(idx_q[1:0])) begin
            push_d.count      = 2'd1;
            push_d.item0.kind = mtne_pkg::KIND_BAD_CHUNK;
            push_d.item0.last = 1'b1;
            halted_d          = 1'b1;
          end else if (idx_q >= mtne_pkg::IdLastIdx) begin
            phase_d = PH_LEN;
            idx_d   = 4'd0;
            chunk_d = '0;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        PH_LEN: begin
          chunk_d = {chunk_q[mtne_pkg::ChunkBits-9:0], byte_q};
          if (idx_q >= mtne_pkg::IdLastIdx) begin
            idx_d = 4'd0;
            if (chunk_d == '0) begin
              phase_d = PH_ID;
              if (collect_q == COL_ACTIVE) begin
                collect_d = COL_DONE;
              end
            end else begin
              phase_d = PH_DELTA;
              delta_d = '0;
            end
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        default: begin
          case (phase_q)
            PH_DELTA: begin
              delta_d = {delta_q[mtne_pkg::DeltaBits-8:0], byte_q[6:0]};
              if (!byte_q[7]) begin
                phase_d = PH_STATUS;
              end
            end
            PH_STATUS: begin
              nib_d  = byte_q[7:4];
              idx_d  = 4'd0;
              skip_d = '0;
              if (byte_q[7:4] == mtne_pkg::NibMeta) begin
                phase_d = (byte_q[3:0] == 4'hF) ? PH_MTYPE : PH_VLEN;
              end else begin
                phase_d = PH_DATA;
              end
            end
            PH_MTYPE: begin
              phase_d = PH_VLEN;
              skip_d  = '0;
            end
            PH_VLEN: begin
              skip_d = {skip_q[mtne_pkg::SkipBits-8:0], byte_q[6:0]};
              if (!byte_q[7]) begin
                if (skip_d == '0) begin
                  phase_d = PH_DELTA;
                  delta_d = '0;
                  idx_d   = 4'd0;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
            end
            PH_SKIP: begin
              skip_d = skip_q - 1'b1;
              if (skip_d == '0) begin
                phase_d = PH_DELTA;
                delta_d = '0;
                idx_d   = 4'd0;
              end
            end
            PH_DATA: begin
              first_d = ev_first;
              if (idx_q == 4'd0 && nib_q != mtne_pkg::NibProgram &&
                  nib_q != mtne_pkg::NibPressure) begin
                idx_d = 4'd1;
              end else begin
                push_d    = ev_push;
                open_d    = ev_open;
                prev_d    = ev_prev;
                collect_d = ev_collect;
                phase_d   = PH_DELTA;
                delta_d   = '0;
                idx_d     = 4'd0;
              end
            end
            default: begin
              phase_d = PH_DELTA;
              delta_d = '0;
              idx_d   = 4'd0;
            end
          endcase
          // every body byte counts against the chunk length
          chunk_d = chunk_q - 1'b1;
          if (chunk_d == '0) begin
            phase_d = PH_ID;
            idx_d   = 4'd0;
            if (collect_d == COL_ACTIVE) begin
              collect_d = COL_DONE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      idx_q     <= '0;
      chunk_q   <= '0;
      delta_q   <= '0;
      skip_q    <= '0;
      nib_q     <= '0;
      first_q   <= '0;
      open_q    <= '0;
      prev_q    <= 1'b0;
      collect_q <= COL_IDLE;
      halted_q  <= 1'b0;
      push_o    <= '0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      chunk_q   <= chunk_d;
      delta_q   <= delta_d;
      skip_q    <= skip_d;
      nib_q     <= nib_d;
      first_q   <= first_d;
      open_q    <= open_d;
      prev_q    <= prev_d;
      collect_q <= collect_d;
      halted_q  <= halted_d;
      push_o    <= push_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mtne_queue.sv */
// ----------------------------------------------------------------------------
// mtne_queue
// Small queue taking up to two results a cycle, handing one out when ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtne_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire mtne_pkg::push_t push_i,
  output logic         room_o,
  mtne_note_if.source  note_o
);

  mtne_pkg::note_t                  entries_q [mtne_pkg::QDepth];
  logic [mtne_pkg::QPtrBits-1:0]    wr_q, wr_d;
  logic [mtne_pkg::QPtrBits-1:0]    rd_q, rd_d;
  logic [mtne_pkg::QCntBits-1:0]    cnt_q, cnt_d;
  logic                             pop;
  logic [mtne_pkg::QPtrBits-1:0]    wr_next;

  // room for two while one push may still be landing
  assign room_o = (cnt_q + mtne_pkg::QCntBits'(push_i.count)) <=
                  mtne_pkg::QCntBits'(mtne_pkg::QDepth - 2);
  assign pop    = note_o.valid && note_o.ready;
  assign wr_next = wr_q + 1'b1;

  assign note_o.valid       = cnt_q != '0;
  assign note_o.kind        = entries_q[rd_q].kind;
  assign note_o.note_number = entries_q[rd_q].note_number;
  assign note_o.last        = entries_q[rd_q].last;

  always_comb begin
    wr_d  = wr_q + push_i.count[mtne_pkg::QPtrBits-1:0];
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + mtne_pkg::QCntBits'(push_i.count) - mtne_pkg::QCntBits'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_q] <= push_i.item0;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_next] <= push_i.item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/midi_track_note_extractor.sv */
// ----------------------------------------------------------------------------
// midi_track_note_extractor
// Parses a standard MIDI file byte stream and reports the note-ons of the
// first track that holds notes, as rests, new-chord and joined-chord notes.
// ----------------------------------------------------------------------------
// byte_i takes one file byte per request, starting at the first byte of the
// file; note_o hands out one result per request, with last set on the final
// result caused by a byte. cfg_we_i writes min_rest_delta from cfg_wdata_i;
// write it only while the block is idle.
// A byte passes an input register, is parsed combinationally and its
// results pass the parser's output register into a four-entry queue whose
// head drives note_o. One byte is accepted per cycle while the queue has
// room; a byte that yields a rest and a note needs two output transfers,
// so the output port sets the sustained rate when rests are frequent.
// Input ready drops while the input register is full and the queue,
// counting the results still being written, holds more than two.
// Reset empties the queue, puts the parser at the start of the file header
// and clears min_rest_delta. A bad header or chunk id yields one error
// result and the block then ignores all bytes until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_track_note_extractor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mtne_byte_if.sink                          byte_i,
  mtne_note_if.source                        note_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mtne_pkg::RestBits-1:0] cfg_wdata_i
);

  mtne_pkg::push_t push;
  logic            room;

  mtne_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .room_i      (room),
    .push_o      (push)
  );

  mtne_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .note_o (note_o)
  );

endmodule

`default_nettype wire
